// ===== design/sdkh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host package
// Shared types, command codes, sizes and the segment glyph table.
// ----------------------------------------------------------------------------
package sdkh_pkg;

   localparam int DIGITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int DEC_DIGITS_MAX = 9;
   localparam int FRAME_LEN = 17;

   localparam logic [7:0] CMD_STROBE = 8'hC0;
   localparam logic [7:0] CMD_READ_KEYS = 8'h42;
   localparam logic [7:0] CMD_DISP_OFF = 8'h88;
   localparam logic [7:0] CMD_DISP_ON = 8'h8A;
   localparam logic [7:0] CMD_BRIGHT = 8'h80;
   localparam logic [7:0] SEG_POINT = 8'h01;
   localparam logic [7:0] SEG_NO_POINT = 8'hFE;

   localparam logic [7:0] SCAN_LOW_A = 8'h04;
   localparam logic [7:0] SCAN_HIGH_A = 8'h40;
   localparam logic [7:0] SCAN_LOW_B = 8'h02;
   localparam logic [7:0] SCAN_HIGH_B = 8'h20;

   localparam logic [4:0] MINUS_CODE = 5'd16;
   localparam logic [28:0] RECIP_TEN = 29'd429496730;

   typedef enum logic [3:0] {
      FN_GLYPH     = 4'd0,
      FN_POINT_ON  = 4'd1,
      FN_POINT_OFF = 4'd2,
      FN_CLEAR     = 4'd3,
      FN_NUMBER    = 4'd4,
      FN_BRIGHT    = 4'd5,
      FN_DISP_OFF  = 4'd6,
      FN_DISP_ON   = 4'd7,
      FN_KEYS      = 4'd8
   } func_type;

   typedef enum logic [2:0] {
      OP_GLYPH,
      OP_POINT_ON,
      OP_POINT_OFF,
      OP_CLEAR,
      OP_NUMBER,
      OP_SINGLE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  place;
      logic [4:0]  glyph;
      logic [27:0] number;
      logic [7:0]  tx_byte;
      logic [4:0]  key_code;
   } cmd_type;

   function automatic logic [7:0] glyph_seg(input logic [4:0] code);
      logic [7:0] seg;
      unique case (code)
         5'd0:    seg = 8'hFC;
         5'd1:    seg = 8'h60;
         5'd2:    seg = 8'hDA;
         5'd3:    seg = 8'hF2;
         5'd4:    seg = 8'h66;
         5'd5:    seg = 8'hB6;
         5'd6:    seg = 8'hBE;
         5'd7:    seg = 8'hE0;
         5'd8:    seg = 8'hFE;
         5'd9:    seg = 8'hF6;
         5'd10:   seg = 8'hEE;
         5'd11:   seg = 8'h3E;
         5'd12:   seg = 8'h9C;
         5'd13:   seg = 8'h7A;
         5'd14:   seg = 8'h9E;
         5'd15:   seg = 8'h8E;
         default: seg = 8'h02;
      endcase
      return seg;
   endfunction

endpackage

// ===== design/sdkh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host front end
// Accepts requests, drops those without effect, decodes key scans and
// control bytes, and pushes a command into the queue.
// ----------------------------------------------------------------------------
module sdkh_front import sdkh_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic [2:0]         req_place,
   input  logic [4:0]         req_glyph,
   input  logic signed [27:0] req_number,
   input  logic [3:0]         req_level,
   input  logic [31:0]        req_key_scan,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic       keep;
   logic [4:0] key;

   always_comb begin
      key = 5'd0;
      for (int b = 0; b < 4; b++) begin
         if (req_key_scan[8*b +: 8] == SCAN_LOW_A) begin
            key = 5'(2*b + 1);
         end else if (req_key_scan[8*b +: 8] == SCAN_HIGH_A) begin
            key = 5'(2*b + 2);
         end
      end
      for (int b = 0; b < 4; b++) begin
         if (req_key_scan[8*b +: 8] == SCAN_LOW_B) begin
            key = 5'(2*b + 9);
         end else if (req_key_scan[8*b +: 8] == SCAN_HIGH_B) begin
            key = 5'(2*b + 10);
         end
      end
   end

   always_comb begin
      keep = 1'b1;
      q_cmd.op = OP_SINGLE;
      q_cmd.place = req_place;
      q_cmd.glyph = req_glyph;
      q_cmd.number = req_number;
      q_cmd.tx_byte = 8'd0;
      q_cmd.key_code = 5'd0;
      unique case (req_func)
         FN_GLYPH:     q_cmd.op = OP_GLYPH;
         FN_POINT_ON:  q_cmd.op = OP_POINT_ON;
         FN_POINT_OFF: q_cmd.op = OP_POINT_OFF;
         FN_CLEAR:     q_cmd.op = OP_CLEAR;
         FN_NUMBER:    q_cmd.op = OP_NUMBER;
         FN_BRIGHT: begin
            keep = ~req_level[3];
            q_cmd.tx_byte = CMD_BRIGHT | {4'd0, req_level};
         end
         FN_DISP_OFF:  q_cmd.tx_byte = CMD_DISP_OFF;
         FN_DISP_ON:   q_cmd.tx_byte = CMD_DISP_ON;
         FN_KEYS: begin
            q_cmd.tx_byte = CMD_READ_KEYS;
            q_cmd.key_code = key;
         end
         default:      keep = 1'b0;
      endcase
   end

   assign req_ready = ~q_full;
   assign q_push = req_valid & req_ready & keep;

endmodule

// ===== design/sdkh_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sdkh_fifo import sdkh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/sdkh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host back end
// Holds the digit buffer, converts numbers to decimal one digit per cycle,
// and sends strobe frames and single bytes through the output register.
// ----------------------------------------------------------------------------
module sdkh_back import sdkh_pkg::*; #(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic [4:0] rsp_key_code,
   output logic       rsp_last
);

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [3:0] DIG4 = 4'(DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_WRITE,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             single_ff, single_in;
   logic [7:0]       sbyte_ff, sbyte_in;
   logic [4:0]       skey_ff, skey_in;
   logic             neg_ff, neg_in;
   logic [27:0]      mag_ff, mag_in;
   logic [3:0]       nd_ff, nd_in;
   logic [3:0]       rev_ff [DEC_DIGITS_MAX];
   logic [3:0]       rev_in [DEC_DIGITS_MAX];
   logic [IDX_W-1:0] wi_ff, wi_in;
   logic [7:0]       seg_ff [DIGITS];
   logic [7:0]       seg_in [DIGITS];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_tx_byte_ff, rsp_tx_byte_in;
   logic [4:0]       rsp_key_code_ff, rsp_key_code_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [56:0]      prod;
   logic [27:0]      quot;
   logic [27:0]      diff;
   logic [3:0]       pidx;
   logic             place_ok;
   logic [3:0]       chars, pad, pos, tpos, ridx;
   logic [7:0]       tbyte;
   logic [2:0]       tcol;
   logic             load;

   assign prod = 57'(mag_ff) * 57'(RECIP_TEN);
   assign quot = {3'd0, prod[56:32]};
   assign diff = mag_ff - ((quot << 3) + (quot << 1));

   assign pidx = DIG4 - 4'd1 - {1'b0, q_cmd.place};
   assign place_ok = ({1'b0, q_cmd.place} < DIG4);

   assign chars = nd_ff + {3'd0, neg_ff};
   assign pad = (chars < DIG4) ? DIG4 - chars : 4'd0;
   assign pos = 4'(wi_ff);
   assign tpos = pos - pad;
   assign ridx = nd_ff - 4'd1 - tpos + {3'd0, neg_ff};

   assign tcol = cnt_ff[3:1];
   assign load = ~rsp_valid_ff | rsp_ready;
   assign q_pop = (state_ff == ST_IDLE) & q_valid;

   always_comb begin
      tbyte = 8'd0;
      for (int j = 0; j < DIGITS; j++) begin
         tbyte[7-j] = seg_ff[j][~tcol];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      single_in = single_ff;
      sbyte_in = sbyte_ff;
      skey_in = skey_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      nd_in = nd_ff;
      rev_in = rev_ff;
      wi_in = wi_ff;
      seg_in = seg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_tx_byte_in = rsp_tx_byte_ff;
      rsp_key_code_in = rsp_key_code_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cnt_in = 5'd0;
               single_in = 1'b0;
               state_in = ST_EMIT;
               unique case (q_cmd.op)
                  OP_GLYPH: begin
                     if (place_ok && q_cmd.glyph <= MINUS_CODE) begin
                        seg_in[pidx[IDX_W-1:0]] = glyph_seg(q_cmd.glyph);
                     end
                  end
                  OP_POINT_ON: begin
                     if (place_ok) begin
                        seg_in[pidx[IDX_W-1:0]] = seg_ff[pidx[IDX_W-1:0]] | SEG_POINT;
                     end
                  end
                  OP_POINT_OFF: begin
                     if (place_ok) begin
                        seg_in[pidx[IDX_W-1:0]] = seg_ff[pidx[IDX_W-1:0]] & SEG_NO_POINT;
                     end
                  end
                  OP_CLEAR: begin
                     for (int k = 0; k < DIGITS; k++) begin
                        seg_in[k] = 8'd0;
                     end
                  end
                  OP_NUMBER: begin
                     neg_in = q_cmd.number[27];
                     mag_in = q_cmd.number[27] ? 28'd0 - q_cmd.number : q_cmd.number;
                     nd_in = 4'd0;
                     state_in = ST_CONV;
                  end
                  OP_SINGLE: begin
                     single_in = 1'b1;
                     sbyte_in = q_cmd.tx_byte;
                     skey_in = q_cmd.key_code;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            rev_in[nd_ff] = diff[3:0];
            nd_in = nd_ff + 4'd1;
            mag_in = quot;
            if (quot == 28'd0) begin
               wi_in = '0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (pos >= pad) begin
               if (neg_ff && tpos == 4'd0) begin
                  seg_in[wi_ff] = glyph_seg(MINUS_CODE);
               end else begin
                  seg_in[wi_ff] = glyph_seg({1'b0, rev_ff[ridx]});
               end
            end
            wi_in = IDX_W'(wi_ff + 1'b1);
            if (pos == DIG4 - 4'd1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (single_ff) begin
                  rsp_tx_byte_in = sbyte_ff;
                  rsp_key_code_in = skey_ff;
                  rsp_last_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rsp_key_code_in = 5'd0;
                  rsp_last_in = (cnt_ff == 5'(FRAME_LEN - 1));
                  if (cnt_ff == 5'd0) begin
                     rsp_tx_byte_in = CMD_STROBE;
                  end else if (cnt_ff[0]) begin
                     rsp_tx_byte_in = tbyte;
                  end else begin
                     rsp_tx_byte_in = 8'd0;
                  end
                  cnt_in = cnt_ff + 5'd1;
                  if (cnt_ff == 5'(FRAME_LEN - 1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIGITS; k++) begin
            seg_ff[k] <= 8'd0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_ff <= seg_in;
      end
      cnt_ff <= cnt_in;
      single_ff <= single_in;
      sbyte_ff <= sbyte_in;
      skey_ff <= skey_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      nd_ff <= nd_in;
      rev_ff <= rev_in;
      wi_ff <= wi_in;
      rsp_tx_byte_ff <= rsp_tx_byte_in;
      rsp_key_code_ff <= rsp_key_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_key_code = rsp_key_code_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ===== design/segment_display_key_host_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host unit
// Host-side controller for an eight-digit seven-segment display and key
// scan chip. Display commands update the digit buffer and send a strobe
// frame of seventeen bytes, one byte per cycle from the output register
// while the receiver is ready. A number display first converts the value
// to decimal one digit per cycle and then writes one buffer entry per
// cycle. Brightness, display on and off and key reads send a single byte.
// A two-entry command queue lets new requests be taken while a frame is
// being sent.
// ----------------------------------------------------------------------------
module segment_display_key_host_unit import sdkh_pkg::*; #(
   parameter int DIGITS = DIGITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_func,
   input  logic [2:0]         req_place,
   input  logic [4:0]         req_glyph,
   input  logic signed [27:0] req_number,
   input  logic [3:0]         req_level,
   input  logic [31:0]        req_key_scan,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_tx_byte,
   output logic [4:0]         rsp_key_code,
   output logic               rsp_last
);

   logic    q_full;
   logic    q_push;
   cmd_type push_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type head_cmd;

   sdkh_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_place    (req_place),
      .req_glyph    (req_glyph),
      .req_number   (req_number),
      .req_level    (req_level),
      .req_key_scan (req_key_scan),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   sdkh_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head_cmd)
   );

   sdkh_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (head_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_key_code (rsp_key_code),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== design/sdkh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sdkh_checker import sdkh_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_tx_byte,
   input logic [4:0]         rsp_key_code,
   input logic               rsp_last
);

   // A stalled result transfer keeps its byte and its last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only the single-byte key read carries a key code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_code != 5'd0 |-> rsp_last && rsp_tx_byte == CMD_READ_KEYS)
      else $error("key code on a byte that is not a key read");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_key_code == 5'd0)
      else $error("key code inside a strobe frame");

   // Every transfer that ends a command is a frame trailer or a control byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_tx_byte == 8'd0 || rsp_tx_byte[7:3] == CMD_BRIGHT[7:3]
         || rsp_tx_byte == CMD_DISP_OFF || rsp_tx_byte == CMD_DISP_ON
         || rsp_tx_byte == CMD_READ_KEYS)
      else $error("unexpected final byte");

endmodule

bind segment_display_key_host_unit sdkh_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment display key host unit testbench
// Drives display, control and key read commands into the unit and checks
// every byte that comes back against a cycle-free predictor of the digit
// buffer, the strobe frame and the key decoder. A directed prologue covers
// the corner cases, then random commands run through a steady phase and
// phases of sender gaps, receiver stalls, both, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import sdkh_pkg::*;

   localparam logic [3:0] BRIGHT_MAX = 4'd7;
   localparam int BLANK_CHAR = -1;

   localparam int RANDOM_ITEMS = 385;
   localparam int PHASE_LEN = 97;
   localparam int HOLD_AT_ITEM = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PRINT_CAP = 40;

   typedef enum int {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_MIXED
   } phase_type;

   typedef struct {
      logic [3:0]  func;
      logic [2:0]  place;
      logic [4:0]  glyph;
      logic [27:0] number;
      logic [3:0]  level;
      logic [31:0] key_scan;
      phase_type   phase;
   } command_type;

   typedef struct packed {
      logic [7:0] tx;
      logic [4:0] key;
      logic       last;
   } chip_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_func = '0;
   logic [2:0] req_place = '0;
   logic [4:0] req_glyph = '0;
   logic signed [27:0] req_number = '0;
   logic [3:0] req_level = '0;
   logic [31:0] req_key_scan = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic [4:0] rsp_key_code;
   logic rsp_last;

   command_type pending_cmds[$];
   command_type on_wire;
   chip_byte_type chip_bytes_due[$];
   logic [7:0] digit_bank [0:DIGITS_DEFAULT-1];
   logic [7:0] seg_font [0:16] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
      8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'h02
   };
   int send_gap_pct [4] = '{0, 48, 0, 38};
   int recv_stall_pct [4] = '{0, 0, 48, 38};
   phase_type live_phase = PH_STEADY;
   int items_taken = 0;
   int hold_left = 0;
   logic hold_used = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   segment_display_key_host_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_place(req_place),
      .req_glyph(req_glyph),
      .req_number(req_number),
      .req_level(req_level),
      .req_key_scan(req_key_scan),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_key_code(rsp_key_code),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic void expect_byte(input logic [7:0] tx, input logic [4:0] key,
                                       input logic last);
      chip_byte_type entry;
      entry.tx = tx;
      entry.key = key;
      entry.last = last;
      chip_bytes_due.push_back(entry);
   endfunction

   // The strobe frame sends the buffer transposed: byte r carries segment
   // bit 7-r of every digit, digit j landing in bit 7-j.
   function automatic void expect_strobe_frame();
      logic [7:0] column;
      int r;
      int j;
      expect_byte(CMD_STROBE, 5'd0, 1'b0);
      for (r = 0; r < 8; r++) begin
         column = '0;
         for (j = 0; j < DIGITS_DEFAULT; j++) begin
            column[7-j] = digit_bank[j][7-r];
         end
         expect_byte(column, 5'd0, 1'b0);
         expect_byte(8'h00, 5'd0, r == 7);
      end
   endfunction

   // Blank padding positions keep their old segments, and text longer than
   // the display is cut to its leftmost characters.
   function automatic void render_number(input logic [27:0] value);
      logic negative;
      logic [31:0] magnitude;
      int rev [12];
      int text [24];
      int nd;
      int len;
      int pad;
      int i;
      negative = value[27];
      magnitude = negative ? (32'h1000_0000 - {4'h0, value}) : {4'h0, value};
      nd = 0;
      do begin
         rev[nd] = int'(magnitude % 10);
         magnitude = magnitude / 10;
         nd++;
      end while (magnitude != 0 && nd < 12);
      pad = DIGITS_DEFAULT - (nd + (negative ? 1 : 0));
      if (pad < 0) begin
         pad = 0;
      end
      len = 0;
      for (i = 0; i < pad; i++) begin
         text[len] = BLANK_CHAR;
         len++;
      end
      if (negative) begin
         text[len] = int'(MINUS_CODE);
         len++;
      end
      for (i = nd - 1; i >= 0; i--) begin
         text[len] = rev[i];
         len++;
      end
      for (i = 0; i < DIGITS_DEFAULT && i < len; i++) begin
         if (text[i] != BLANK_CHAR) begin
            digit_bank[i] = seg_font[text[i]];
         end
      end
   endfunction

   // Later matches override earlier ones, and the second pair of patterns
   // is tested after the first.
   function automatic logic [4:0] decode_scan(input logic [31:0] scan);
      logic [4:0] key;
      logic [7:0] lane;
      int b;
      key = 5'd0;
      for (b = 0; b < 4; b++) begin
         lane = scan[8*b +: 8];
         if (lane == SCAN_LOW_A) key = 5'(2 * b + 1);
         else if (lane == SCAN_HIGH_A) key = 5'(2 * b + 2);
      end
      for (b = 0; b < 4; b++) begin
         lane = scan[8*b +: 8];
         if (lane == SCAN_LOW_B) key = 5'(2 * b + 9);
         else if (lane == SCAN_HIGH_B) key = 5'(2 * b + 10);
      end
      return key;
   endfunction

   function automatic void predict_command(input command_type c);
      int slot;
      logic slot_ok;
      slot_ok = int'(c.place) < DIGITS_DEFAULT;
      slot = DIGITS_DEFAULT - 1 - int'(c.place);
      case (c.func)
         FN_GLYPH: begin
            if (slot_ok && c.glyph <= MINUS_CODE) begin
               digit_bank[slot] = seg_font[c.glyph];
            end
            expect_strobe_frame();
         end
         FN_POINT_ON: begin
            if (slot_ok) digit_bank[slot] = digit_bank[slot] | SEG_POINT;
            expect_strobe_frame();
         end
         FN_POINT_OFF: begin
            if (slot_ok) digit_bank[slot] = digit_bank[slot] & SEG_NO_POINT;
            expect_strobe_frame();
         end
         FN_CLEAR: begin
            foreach (digit_bank[k]) digit_bank[k] = 8'h00;
            expect_strobe_frame();
         end
         FN_NUMBER: begin
            render_number(c.number);
            expect_strobe_frame();
         end
         FN_BRIGHT: begin
            if (c.level <= BRIGHT_MAX) begin
               expect_byte(CMD_BRIGHT | {4'h0, c.level}, 5'd0, 1'b1);
            end
         end
         FN_DISP_OFF: expect_byte(CMD_DISP_OFF, 5'd0, 1'b1);
         FN_DISP_ON: expect_byte(CMD_DISP_ON, 5'd0, 1'b1);
         FN_KEYS: expect_byte(CMD_READ_KEYS, decode_scan(c.key_scan), 1'b1);
         default: ;
      endcase
   endfunction

   function automatic command_type make_cmd(input logic [3:0] func, input logic [2:0] place,
                                            input logic [4:0] glyph,
                                            input logic [27:0] number,
                                            input logic [3:0] level, input logic [31:0] scan,
                                            input phase_type phase);
      command_type c;
      c.func = func;
      c.place = place;
      c.glyph = glyph;
      c.number = number;
      c.level = level;
      c.key_scan = scan;
      c.phase = phase;
      return c;
   endfunction

   function automatic logic [31:0] random_scan();
      logic [31:0] scan;
      int b;
      if ($urandom_range(0, 4) == 0) begin
         return $urandom;
      end
      for (b = 0; b < 4; b++) begin
         case ($urandom_range(0, 5))
            0: scan[8*b +: 8] = SCAN_LOW_A;
            1: scan[8*b +: 8] = SCAN_HIGH_A;
            2: scan[8*b +: 8] = SCAN_LOW_B;
            3: scan[8*b +: 8] = SCAN_HIGH_B;
            4: scan[8*b +: 8] = 8'h00;
            default: scan[8*b +: 8] = 8'($urandom);
         endcase
      end
      return scan;
   endfunction

   function automatic logic [27:0] random_number();
      int v;
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, 999));
         1: v = -int'($urandom_range(1, 9999));
         2: v = int'($urandom_range(0, 99999999));
         3: v = -int'($urandom_range(1, 9999999));
         4: v = int'($urandom);
         default: v = int'($urandom_range(0, 9));
      endcase
      return v[27:0];
   endfunction

   function automatic command_type random_cmd(input phase_type phase);
      command_type c;
      int pick;
      c = make_cmd(FN_GLYPH, 3'($urandom), 5'($urandom_range(0, 16)), random_number(),
                   4'($urandom), random_scan(), phase);
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
         c.func = FN_GLYPH;
         if ($urandom_range(0, 9) == 0) c.glyph = 5'($urandom);
      end else if (pick < 7) begin
         c.func = FN_POINT_ON;
      end else if (pick < 9) begin
         c.func = FN_POINT_OFF;
      end else if (pick < 10) begin
         c.func = FN_CLEAR;
      end else if (pick < 14) begin
         c.func = FN_NUMBER;
      end else if (pick < 16) begin
         c.func = FN_BRIGHT;
      end else if (pick < 17) begin
         c.func = $urandom_range(0, 1) ? FN_DISP_ON : FN_DISP_OFF;
      end else if (pick < 19) begin
         c.func = FN_KEYS;
      end else begin
         c.func = $urandom_range(0, 1) ? FN_KEYS : 4'($urandom_range(15, FN_KEYS + 1));
      end
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_command(on_wire);
            items_taken <= items_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() != 0 &&
                $urandom_range(0, 99) >= send_gap_pct[int'(pending_cmds[0].phase)]) begin
               on_wire = pending_cmds.pop_front();
               req_func <= on_wire.func;
               req_place <= on_wire.place;
               req_glyph <= on_wire.glyph;
               req_number <= on_wire.number;
               req_level <= on_wire.level;
               req_key_scan <= on_wire.key_scan;
               live_phase <= on_wire.phase;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_used && items_taken >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= hold_left == 0 &&
                      $urandom_range(0, 99) >= recv_stall_pct[int'(live_phase)];
      end
   end

   always @(posedge clock) begin
      chip_byte_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (chip_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer tx=%h key=%0d last=%b",
                                      rsp_tx_byte, rsp_key_code, rsp_last));
         end else begin
            due = chip_bytes_due.pop_front();
            if (rsp_tx_byte !== due.tx) begin
               report_mismatch($sformatf("tx_byte %h, expected %h", rsp_tx_byte, due.tx));
            end
            if (rsp_key_code !== due.key) begin
               report_mismatch($sformatf("key_code %0d, expected %0d",
                                         rsp_key_code, due.key));
            end
            if (rsp_last !== due.last) begin
               report_mismatch($sformatf("last %b, expected %b", rsp_last, due.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int n;
      foreach (digit_bank[k]) digit_bank[k] = 8'h00;

      pending_cmds.push_back(make_cmd(FN_GLYPH, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0, PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_GLYPH, 3'd7, 5'd15, 28'hFFFFFFF, 4'hF,
                                      32'hFFFFFFFF, PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_GLYPH, 3'd3, MINUS_CODE, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_GLYPH, 3'd5, 5'd31, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_POINT_ON, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_POINT_ON, 3'd7, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_POINT_OFF, 3'd7, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, 28'd5, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, 28'd99999999, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, -28'sd9999999, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, 28'h7FFFFFF, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, 28'h8000000, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_NUMBER, 3'd0, 5'd0, 28'hFFFFFFF, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_CLEAR, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_BRIGHT, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_BRIGHT, 3'd0, 5'd0, 28'd0, BRIGHT_MAX, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_BRIGHT, 3'd0, 5'd0, 28'd0, BRIGHT_MAX + 4'd1,
                                      32'd0, PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_BRIGHT, 3'd0, 5'd0, 28'd0, 4'hF, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_DISP_OFF, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_DISP_ON, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_KEYS, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_KEYS, 3'd0, 5'd0, 28'd0, 4'd0, 32'h40404040,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_KEYS, 3'd0, 5'd0, 28'd0, 4'd0, 32'h20000004,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(FN_KEYS + 4'd1, 3'd0, 5'd0, 28'd0, 4'd0, 32'd0,
                                      PH_STEADY));
      pending_cmds.push_back(make_cmd(4'hF, 3'd7, 5'd31, 28'hFFFFFFF, 4'hF, 32'hFFFFFFFF,
                                      PH_STEADY));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pending_cmds.push_back(random_cmd(phase_type'(n / PHASE_LEN)));
      end

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (chip_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
